@@ sv/ecd_pkg.sv @@
// Shared constants and types of the epoch seconds to civil date converter.
`default_nettype none

package ecd_pkg;

  // Day bias: shift the epoch to 0000-03-01 and add 40 eras so every day count is non-negative
  localparam longint unsigned DayBias = 64'd719468 + 64'd40 * 64'd146097;
  localparam logic [40:0] SecBias = 41'(DayBias * 64'd86400);

  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [9:0]  DivSecHi   = 10'd675;
  localparam logic [17:0] DaysPerEra = 18'd146097;
  localparam logic [17:0] LastDoe    = 18'd146096;
  localparam logic [11:0] SecsPerHr  = 12'd3600;
  localparam logic [5:0]  SecsPerMin = 6'd60;
  localparam logic [8:0]  DaysPerYr  = 9'd365;
  localparam logic [8:0]  DaysPer5Mo = 9'd153;
  localparam logic [16:0] YearBase   = 17'(40 * 400 + 1900);

  // Reciprocals for division by constants
  localparam logic [24:0] Recip675   = 25'((64'd1 << 34) / 64'd675);
  localparam logic [24:0] RecipEra   = 25'((64'd1 << 42) / 64'd146097 + 64'd1);
  localparam logic [17:0] RecipHour  = 18'((64'd1 << 29) / 64'd3600 + 64'd1);
  localparam logic [18:0] Recip1460  = 19'((64'd1 << 29) / 64'd1460 + 64'd1);
  localparam logic [18:0] Recip36524 = 19'((64'd1 << 34) / 64'd36524 + 64'd1);
  localparam logic [12:0] RecipMin   = 13'((64'd1 << 18) / 64'd60 + 64'd1);
  localparam logic [18:0] Recip365   = 19'((64'd1 << 27) / 64'd365 + 64'd1);
  localparam logic [9:0]  Recip100   = 10'((64'd1 << 16) / 64'd100 + 64'd1);
  localparam logic [11:0] Recip153   = 12'((64'd1 << 19) / 64'd153 + 64'd1);
  localparam logic [11:0] Recip5     = 12'((64'd1 << 14) / 64'd5 + 64'd1);

  typedef struct packed {
    logic [23:0] day;
    logic [16:0] secs;
  } split_t;

endpackage

`default_nettype wire

@@ sv/ecd_if.sv @@
// Handshake channels of the converter: timestamp in, civil date and time out.
`default_nettype none

interface ecd_in_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] year_since_1900;
  logic        [3:0]  month_index;
  logic        [4:0]  day_of_month;
  logic        [4:0]  hour_of_day;
  logic        [5:0]  minute_of_hour;
  logic        [5:0]  second_of_minute;

  modport source (output valid, output year_since_1900, output month_index,
                  output day_of_month, output hour_of_day, output minute_of_hour,
                  output second_of_minute, input ready);
  modport sink   (input valid, input year_since_1900, input month_index,
                  input day_of_month, input hour_of_day, input minute_of_hour,
                  input second_of_minute, output ready);
endinterface

`default_nettype wire

@@ sv/ecd_split.sv @@
// Four-stage pipeline: add zone offset, floor-split seconds into biased day and second of day.
`default_nettype none

module ecd_split (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic signed [16:0]  off_i,
  ecd_in_if.sink                   in_i,
  output logic                     split_vld_o,
  input  wire logic                split_rdy_i,
  output ecd_pkg::split_t          split_o
);

  localparam int NumStages = 4;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] rdy;

  logic [40:0] s_d, s_q;
  logic [48:0] prod_d, prod_q;
  logic [33:0] q1_q;
  logic [6:0]  r7a_q, r7b_q;
  logic [23:0] qe_d, qe_q;
  logic [33:0] rfull;
  logic [11:0] rem_d, rem_q;
  logic        ge1, ge2, ge3;
  logic [1:0]  corr;
  logic [11:0] sub;
  logic [11:0] rday;
  ecd_pkg::split_t word_d, word_q;

  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || split_rdy_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_i.ready  = rdy[0];
  assign split_vld_o = vld_q[NumStages-1];
  assign split_o     = word_q;

  always_comb begin
    s_d = {in_i.epoch_seconds[39], in_i.epoch_seconds} + {{24{off_i[16]}}, off_i}
        + ecd_pkg::SecBias;
    prod_d = 49'(s_q[40:17]) * 49'(ecd_pkg::Recip675);
    qe_d   = prod_q[47:24];
    rfull  = q1_q - 34'(qe_d) * 34'(ecd_pkg::DivSecHi);
    rem_d  = rfull[11:0];
    ge1 = rem_q >= 12'(ecd_pkg::DivSecHi);
    ge2 = rem_q >= 12'(ecd_pkg::DivSecHi) * 12'd2;
    ge3 = rem_q >= 12'(ecd_pkg::DivSecHi) * 12'd3;
    corr = {1'b0, ge1} + {1'b0, ge2} + {1'b0, ge3};
    sub  = 12'(corr) * 12'(ecd_pkg::DivSecHi);
    rday = rem_q - sub;
    word_d.day  = qe_q + 24'(corr);
    word_d.secs = {rday[9:0], r7b_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s_q <= s_d;
    end
    if (rdy[1]) begin
      prod_q <= prod_d;
      q1_q   <= s_q[40:7];
      r7a_q  <= s_q[6:0];
    end
    if (rdy[2]) begin
      qe_q  <= qe_d;
      rem_q <= rem_d;
      r7b_q <= r7a_q;
    end
    if (rdy[3]) begin
      word_q <= word_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/ecd_civil.sv @@
// Seven-stage pipeline: biased day count to year, month and day; second of day to h:m:s.
`default_nettype none

module ecd_civil (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           split_vld_i,
  output logic                split_rdy_o,
  input  wire ecd_pkg::split_t split_i,
  ecd_out_if.source           out_o
);

  localparam int NumStages = 7;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] rdy;

  // stage 0
  logic [48:0] era_prod;
  logic [34:0] hr_prod;
  logic [6:0]  era0_q;
  logic [23:0] day0_q;
  logic [4:0]  hr0_q;
  logic [16:0] secs0_q;
  // stage 1
  logic [23:0] doe_full;
  logic [16:0] rem_full;
  logic [6:0]  era1_q;
  logic [17:0] doe1_q;
  logic [4:0]  hr1_q;
  logic [11:0] rem1_q;
  // stage 2
  logic [36:0] p1460, p36524;
  logic [24:0] min_prod;
  logic [6:0]  era2_q;
  logic [17:0] doe2_q;
  logic [6:0]  d1460_q;
  logic [2:0]  d36524_q;
  logic        last_q;
  logic [4:0]  hr2_q;
  logic [11:0] rem2_q;
  logic [5:0]  min2_q;
  // stage 3
  logic [17:0] n_d;
  logic [36:0] yoe_prod;
  logic [11:0] sec_full;
  logic [6:0]  era3_q;
  logic [17:0] doe3_q;
  logic [8:0]  yoe3_q;
  logic [4:0]  hr3_q;
  logic [5:0]  min3_q, sec3_q;
  // stage 4
  logic [18:0] y100_prod;
  logic [17:0] ystart;
  logic [17:0] doy_full;
  logic [6:0]  era4_q;
  logic [8:0]  yoe4_q, doy4_q;
  logic [4:0]  hr4_q;
  logic [5:0]  min4_q, sec4_q;
  // stage 5
  logic [10:0] t5_in;
  logic [22:0] mp_prod;
  logic [6:0]  era5_q;
  logic [8:0]  yoe5_q, doy5_q;
  logic [3:0]  mp5_q;
  logic [4:0]  hr5_q;
  logic [5:0]  min5_q, sec5_q;
  // stage 6
  logic [10:0] t153;
  logic [22:0] q5_prod;
  logic [8:0]  mday_full;
  logic [16:0] year_d;
  logic [3:0]  mon_d;
  logic signed [15:0] year_q;
  logic [3:0]  mon_q;
  logic [4:0]  mday_q, hr6_q;
  logic [5:0]  min6_q, sec6_q;

  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || out_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign split_rdy_o = rdy[0];

  always_comb begin
    era_prod  = 49'(split_i.day) * 49'(ecd_pkg::RecipEra);
    hr_prod   = 35'(split_i.secs) * 35'(ecd_pkg::RecipHour);
    doe_full  = day0_q - 24'(era0_q) * 24'(ecd_pkg::DaysPerEra);
    rem_full  = secs0_q - 17'(hr0_q) * 17'(ecd_pkg::SecsPerHr);
    p1460     = 37'(doe1_q) * 37'(ecd_pkg::Recip1460);
    p36524    = 37'(doe1_q) * 37'(ecd_pkg::Recip36524);
    min_prod  = 25'(rem1_q) * 25'(ecd_pkg::RecipMin);
    n_d       = doe2_q - 18'(d1460_q) + 18'(d36524_q) - 18'(last_q);
    yoe_prod  = 37'(n_d) * 37'(ecd_pkg::Recip365);
    sec_full  = rem2_q - 12'(min2_q) * 12'(ecd_pkg::SecsPerMin);
    y100_prod = 19'(yoe3_q) * 19'(ecd_pkg::Recip100);
    ystart    = 18'(yoe3_q) * 18'(ecd_pkg::DaysPerYr) + 18'(yoe3_q[8:2])
              - 18'(y100_prod[18:16]);
    doy_full  = doe3_q - ystart;
    t5_in     = 11'(doy4_q) * 11'd5 + 11'd2;
    mp_prod   = 23'(t5_in) * 23'(ecd_pkg::Recip153);
    t153      = 11'(mp5_q) * 11'(ecd_pkg::DaysPer5Mo) + 11'd2;
    q5_prod   = 23'(t153) * 23'(ecd_pkg::Recip5);
    mday_full = doy5_q - q5_prod[22:14] + 9'd1;
    mon_d     = (mp5_q < 4'd10) ? mp5_q + 4'd2 : mp5_q - 4'd10;
    year_d    = 17'(yoe5_q) + 17'(era5_q) * 17'd400 + 17'(mp5_q >= 4'd10)
              - ecd_pkg::YearBase;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= split_vld_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      era0_q  <= era_prod[48:42];
      day0_q  <= split_i.day;
      hr0_q   <= hr_prod[33:29];
      secs0_q <= split_i.secs;
    end
    if (rdy[1]) begin
      era1_q <= era0_q;
      doe1_q <= doe_full[17:0];
      hr1_q  <= hr0_q;
      rem1_q <= rem_full[11:0];
    end
    if (rdy[2]) begin
      era2_q   <= era1_q;
      doe2_q   <= doe1_q;
      d1460_q  <= p1460[35:29];
      d36524_q <= p36524[36:34];
      last_q   <= doe1_q == ecd_pkg::LastDoe;
      hr2_q    <= hr1_q;
      rem2_q   <= rem1_q;
      min2_q   <= min_prod[23:18];
    end
    if (rdy[3]) begin
      era3_q <= era2_q;
      doe3_q <= doe2_q;
      yoe3_q <= yoe_prod[35:27];
      hr3_q  <= hr2_q;
      min3_q <= min2_q;
      sec3_q <= sec_full[5:0];
    end
    if (rdy[4]) begin
      era4_q <= era3_q;
      yoe4_q <= yoe3_q;
      doy4_q <= doy_full[8:0];
      hr4_q  <= hr3_q;
      min4_q <= min3_q;
      sec4_q <= sec3_q;
    end
    if (rdy[5]) begin
      era5_q <= era4_q;
      yoe5_q <= yoe4_q;
      doy5_q <= doy4_q;
      mp5_q  <= mp_prod[22:19];
      hr5_q  <= hr4_q;
      min5_q <= min4_q;
      sec5_q <= sec4_q;
    end
    if (rdy[6]) begin
      year_q <= signed'(year_d[15:0]);
      mon_q  <= mon_d;
      mday_q <= mday_full[4:0];
      hr6_q  <= hr5_q;
      min6_q <= min5_q;
      sec6_q <= sec5_q;
    end
  end

  assign out_o.valid            = vld_q[NumStages-1];
  assign out_o.year_since_1900  = year_q;
  assign out_o.month_index      = mon_q;
  assign out_o.day_of_month     = mday_q;
  assign out_o.hour_of_day      = hr6_q;
  assign out_o.minute_of_hour   = min6_q;
  assign out_o.second_of_minute = sec6_q;

endmodule

`default_nettype wire

@@ sv/epoch_seconds_to_civil_date.sv @@
// Top level: zone offset register, split pipeline and civil date pipeline.
//
// in_i carries one signed 40-bit Unix timestamp per word; out_o returns one
// word per input with year minus 1900, month 0..11, day of month, hour,
// minute and second in the proleptic Gregorian calendar, floor-split so
// times before 1970 land on the correct earlier day.
// cfg_we_i/cfg_wdata_i load the signed 17-bit zone offset, added to every
// timestamp; write it only while no word is in flight.
// From input handshake to out_o, 4 stages form the day count and second of day, and
// 7 stages form the date and time of day.
// Each stage holds at most one constant-reciprocal multiply on any path.
// Throughput is one word per cycle while out_o does not stall.
// Reset clears every stage valid bit and sets the offset to 0.
// When out_o stalls, the final stage holds its word; earlier stages keep
// filling bubbles, so in_i.ready drops only once all 11 stages hold words.
`default_nettype none

module epoch_seconds_to_civil_date (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic signed [16:0] cfg_wdata_i,
  ecd_in_if.sink                  in_i,
  ecd_out_if.source               out_o
);

  logic signed [16:0] off_q;
  logic               split_vld;
  logic               split_rdy;
  ecd_pkg::split_t    split_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else if (cfg_we_i) begin
      off_q <= cfg_wdata_i;
    end
  end

  ecd_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .off_i       (off_q),
    .in_i        (in_i),
    .split_vld_o (split_vld),
    .split_rdy_i (split_rdy),
    .split_o     (split_word)
  );

  ecd_civil u_civil (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .split_vld_i (split_vld),
    .split_rdy_o (split_rdy),
    .split_i     (split_word),
    .out_o       (out_o)
  );

  a_split_secs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    split_vld |-> split_word.secs < ecd_pkg::SecsPerDay)
    else $error("second of day out of range");

  a_split_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    split_vld && !split_rdy |=> split_vld && $stable(split_word))
    else $error("internal word dropped or changed under stall");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.month_index <= 4'd11 && out_o.day_of_month != 5'd0 &&
                    out_o.hour_of_day <= 5'd23 && out_o.minute_of_hour <= 6'd59 &&
                    out_o.second_of_minute <= 6'd59)
    else $error("result field out of range");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the epoch seconds to civil date converter.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic signed [15:0] year;
    logic        [3:0]  month;
    logic        [4:0]  mday;
    logic        [4:0]  hour;
    logic        [5:0]  minute;
    logic        [5:0]  second;
  } civil_t;

  typedef struct {
    logic signed [39:0] epoch;
    logic signed [16:0] zone;
    bit                 typed;
    civil_t             want;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic signed [16:0] cfg_wdata;

  ecd_in_if  stamp_ch ();
  ecd_out_if civil_ch ();

  epoch_seconds_to_civil_date dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (stamp_ch),
    .out_o      (civil_ch)
  );

  civil_t             civil_q[$];
  stim_row_t          stim_table[$];
  logic signed [16:0] zone_now;
  bit                 idle_on;
  bit                 row_typed;
  civil_t             row_want;
  int                 mismatch_count;
  int                 stall_left;
  logic               ready_next;
  civil_t             want;
  civil_t             got;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2ms;
    $display("epoch_seconds_to_civil_date regression: fail");
    $finish;
  end

  function automatic civil_t civil_of(logic signed [39:0] epoch, logic signed [16:0] zone);
    longint t, days, sod, z, era, doe, yoe, doy, mp, mon, yr;
    civil_t c;
    t    = longint'(epoch) + longint'(zone);
    days = t / 86400;
    sod  = t % 86400;
    if (sod < 0) begin
      sod  = sod + 86400;
      days = days - 1;
    end
    z   = days + 719468;
    era = (z >= 0 ? z : z - 146096) / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    mon = (mp < 10) ? mp + 3 : mp - 9;
    yr  = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
    c.year   = 16'(yr - 1900);
    c.month  = 4'(mon - 1);
    c.mday   = 5'(doy - (153 * mp + 2) / 5 + 1);
    c.hour   = 5'(sod / 3600);
    c.minute = 6'((sod % 3600) / 60);
    c.second = 6'(sod % 60);
    return c;
  endfunction

  function automatic logic signed [39:0] random_epoch();
    longint             k;
    logic signed [39:0] e;
    case ($urandom_range(0, 5))
      0: e = 40'({$urandom, $urandom});
      1: e = 40'(longint'(int'($urandom)));
      2: begin
        k = longint'($urandom_range(0, 12700000)) - 64'sd6350000;
        e = 40'(k * 86400 + longint'($urandom_range(0, 4)) - 2);
      end
      3: begin
        if ($urandom_range(0, 1) == 1) e = 40'sh7F_FFFF_FFFF - 40'($urandom_range(0, 200000));
        else e = 40'sh80_0000_0000 + 40'($urandom_range(0, 200000));
      end
      4: begin
        k = longint'($urandom_range(0, 80)) - 38;
        e = 40'((k * 146097 - 719468 + longint'($urandom_range(0, 4)) - 2) * 86400
                + longint'($urandom_range(0, 86399)));
      end
      default: e = 40'($urandom);
    endcase
    return e;
  endfunction

  task automatic add_row(input logic signed [39:0] epoch, input logic signed [16:0] zone,
                         input bit typed, input int yr, input int mo, input int md,
                         input int hr, input int mn, input int sc);
    stim_row_t r;
    r.epoch       = epoch;
    r.zone        = zone;
    r.typed       = typed;
    r.want.year   = 16'(yr);
    r.want.month  = 4'(mo);
    r.want.mday   = 5'(md);
    r.want.hour   = 5'(hr);
    r.want.minute = 6'(mn);
    r.want.second = 6'(sc);
    stim_table.push_back(r);
  endtask

  task automatic load_zone(input logic signed [16:0] zone);
    stamp_ch.valid <= 1'b0;
    @(posedge clk);
    while (civil_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= zone;
    @(posedge clk);
    cfg_we   <= 1'b0;
    zone_now = zone;
  endtask

  task automatic push_word(input logic signed [39:0] epoch, input bit typed, input civil_t w);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      stamp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stamp_ch.valid         <= 1'b1;
    stamp_ch.epoch_seconds <= epoch;
    row_typed              <= typed;
    row_want               <= w;
    @(posedge clk);
    while (!stamp_ch.ready) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // hold ready low in random bursts
  always @(posedge clk) begin
    if (!idle_on) begin
      ready_next = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
    end
    civil_ch.ready <= ready_next;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (stamp_ch.valid && stamp_ch.ready) begin
        civil_q.push_back(row_typed ? row_want : civil_of(stamp_ch.epoch_seconds, zone_now));
      end
      if (civil_ch.valid && civil_ch.ready) begin
        got.year   = civil_ch.year_since_1900;
        got.month  = civil_ch.month_index;
        got.mday   = civil_ch.day_of_month;
        got.hour   = civil_ch.hour_of_day;
        got.minute = civil_ch.minute_of_hour;
        got.second = civil_ch.second_of_minute;
        if (civil_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %0d-%0d-%0d %0d:%0d:%0d", $time,
                   got.year, got.month, got.mday, got.hour, got.minute, got.second);
          mismatch_count++;
        end else begin
          want = civil_q.pop_front();
          check_field("year_since_1900", longint'(want.year), longint'(got.year));
          check_field("month_index", want.month, got.month);
          check_field("day_of_month", want.mday, got.mday);
          check_field("hour_of_day", want.hour, got.hour);
          check_field("minute_of_hour", want.minute, got.minute);
          check_field("second_of_minute", want.second, got.second);
        end
      end
    end
  end

  initial begin
    logic signed [16:0] zone;
    stamp_ch.valid         = 1'b0;
    stamp_ch.epoch_seconds = '0;
    civil_ch.ready         = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    row_typed              = 1'b0;
    row_want               = '0;
    zone_now               = '0;
    idle_on                = 1'b1;
    mismatch_count         = 0;
    stall_left             = 0;
    rst_n                  = 1'b0;

    add_row(40'sd0, 17'sd0, 1, 70, 0, 1, 0, 0, 0);
    add_row(-40'sd1, 17'sd0, 1, 69, 11, 31, 23, 59, 59);
    add_row(40'sd86399, 17'sd0, 1, 70, 0, 1, 23, 59, 59);
    add_row(40'sd86400, 17'sd0, 1, 70, 0, 2, 0, 0, 0);
    add_row(40'sd951782400, 17'sd0, 1, 100, 1, 29, 0, 0, 0);
    add_row(-40'sd86400, 17'sd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-40'sd86401, 17'sd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(40'sd1234567890, 17'sd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-40'sd2203891200, 17'sd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-40'sd2203891201, 17'sd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-40'sd62167219200, 17'sd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-40'sd62167219201, 17'sd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(40'sd4107542400, 17'sd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(40'sd4107542399, 17'sd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(40'sd253402300799, 17'sd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(40'sh7F_FFFF_FFFF, 17'sd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(40'sh80_0000_0000, 17'sd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(40'sh7F_FFFF_FFFF, 17'sd50400, 0, 0, 0, 0, 0, 0, 0);
    add_row(40'sh80_0000_0000, 17'sd50400, 0, 0, 0, 0, 0, 0, 0);
    add_row(40'sh7F_FFFF_FFFF, -17'sd50400, 0, 0, 0, 0, 0, 0, 0);
    add_row(40'sh80_0000_0000, -17'sd50400, 0, 0, 0, 0, 0, 0, 0);
    add_row(40'sd0, 17'sh0FFFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(40'sh7F_FFFF_FFFF, 17'sh0FFFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(40'sd0, 17'sh10000, 0, 0, 0, 0, 0, 0, 0);
    add_row(40'sh80_0000_0000, 17'sh10000, 0, 0, 0, 0, 0, 0, 0);
    add_row(-40'sd3600, 17'sd3600, 1, 70, 0, 1, 0, 0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_zone(17'sd0);
    foreach (stim_table[i]) begin
      if (stim_table[i].zone != zone_now) load_zone(stim_table[i].zone);
      push_word(stim_table[i].epoch, stim_table[i].typed, stim_table[i].want);
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        1: zone = 17'sd50400;
        2: zone = -17'sd50400;
        3: zone = 17'($urandom);
        5: zone = 17'sh10000;
        6: zone = 17'sh0FFFF;
        default: zone = 17'(int'($urandom_range(0, 100800)) - 50400);
      endcase
      load_zone(zone);
      idle_on = (p != 7);
      for (int n = 0; n < 125; n++) push_word(random_epoch(), 1'b0, '0);
    end

    stamp_ch.valid <= 1'b0;
    while (civil_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && civil_q.size() == 0) begin
      $display("epoch_seconds_to_civil_date regression: pass");
    end else begin
      $display("epoch_seconds_to_civil_date regression: fail");
    end
    $finish;
  end

endmodule
